// File: hdl/mspm_pkg.sv
`timescale 1ns / 1ps
package mspm_pkg;

    localparam int REQ_W    = 2;
    localparam int CHAR_W   = 7;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 4;
    localparam int POS_W    = 16;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_t REQ_PATTERN = 2'd0;
    localparam req_t REQ_BUILD   = 2'd1;
    localparam req_t REQ_TEXT    = 2'd2;
    localparam req_t REQ_FINISH  = 2'd3;

    localparam status_t ST_REPORT   = 2'd0;
    localparam status_t ST_BUILT    = 2'd1;
    localparam status_t ST_PHASE    = 2'd2;
    localparam status_t ST_CAPACITY = 2'd3;

    localparam logic [POS_W-1:0] POS_SAT = '1;

endpackage

// File: hdl/mspm_if.sv
`timescale 1ns / 1ps
interface mspm_req_if
    import mspm_pkg::*;
;
    logic              valid;
    logic              ready;
    req_t              req_type;
    logic [CHAR_W-1:0] char_code;
    logic              pattern_end;

    modport source (output valid, req_type, char_code, pattern_end, input ready);
    modport sink   (input valid, req_type, char_code, pattern_end, output ready);
endinterface

interface mspm_rsp_if
    import mspm_pkg::*;
;
    logic             valid;
    logic             ready;
    status_t          status;
    logic [ID_W-1:0]  pattern_id;
    logic             found;
    logic [POS_W-1:0] start_pos;
    logic             last;

    modport source (output valid, status, pattern_id, found, start_pos, last, input ready);
    modport sink   (input valid, status, pattern_id, found, start_pos, last, output ready);
endinterface

// File: hdl/mspm_ram.sv
`timescale 1ns / 1ps
module mspm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/multi_pattern_string_matcher.sv
`timescale 1ns / 1ps
// multi-pattern string matcher (aho-corasick automaton)
// req channel: one transaction per request; req_type selects pattern byte, build,
// text byte or finish. rsp channel: result transactions; last marks the final
// result of a request.
// pattern bytes walk the trie in the transition memory; the last byte also does
// an accept mask read-modify-write. an invalid or skipped byte reads no edge.
// a text byte reads the transition memory, then the accept mask; the next byte
// waits for these dependent reads (an invalid character reads only the mask).
// build walks every node breadth first: per node it dequeues and reads the
// queue and failure link; per character it reads the node's and the failure
// node's edge (single read port of the transition memory) and commits, merging
// the accept masks for a child. a single-result request loads the output
// register via S_RESP. finish gives one result per pattern, one per cycle while
// rsp is not stalled. after reset a clearing pass writes zero over the whole
// transition memory (MAX_NODES*ALPHABET, 32768 by default); req.ready stays low
// meanwhile. results sit in an output register: a new request is taken while a
// result waits; a request that makes a result waits in turn while rsp stalls.
module multi_pattern_string_matcher
    import mspm_pkg::*;
#(
    parameter int      MAX_NODES    = 256,
    parameter int      ALPHABET     = 128,
    parameter int      MAX_PATTERNS = 16,
    parameter longint  MAX_TEXT     = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    mspm_req_if.sink   req,
    mspm_rsp_if.source rsp
);
    localparam int DEPTH = MAX_NODES * ALPHABET;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_NODES);
    localparam int NCW   = $clog2(MAX_NODES + 1);
    localparam int CW    = $clog2(ALPHABET);
    localparam int PCW   = $clog2(MAX_PATTERNS + 1);
    localparam int PIW   = MAX_PATTERNS > 1 ? $clog2(MAX_PATTERNS) : 1;
    localparam int TW    = $clog2(MAX_TEXT + 1);
    localparam int TRW   = NW + 1;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_INS    = 5'd2;
    localparam logic [4:0] S_ACC    = 5'd3;
    localparam logic [4:0] S_RESP   = 5'd4;
    localparam logic [4:0] S_TXT_T  = 5'd5;
    localparam logic [4:0] S_TXT_A  = 5'd6;
    localparam logic [4:0] S_REPORT = 5'd7;
    localparam logic [4:0] S_B_RT   = 5'd8;
    localparam logic [4:0] S_B_RF   = 5'd9;
    localparam logic [4:0] S_B_C    = 5'd10;
    localparam logic [4:0] S_B_A1   = 5'd11;
    localparam logic [4:0] S_B_A2   = 5'd12;
    localparam logic [4:0] S_B_DEQ  = 5'd13;
    localparam logic [4:0] S_B_DQ2  = 5'd14;
    localparam logic [4:0] S_B_DQ3  = 5'd15;

    // state registers
    logic [4:0]              state_reg, state_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [NCW-1:0]          nc_reg, nc_next;
    logic [PCW-1:0]          pc_reg, pc_next;
    logic                    built_reg, built_next;
    logic                    skip_reg, skip_next;
    logic [NW-1:0]           cursor_reg, cursor_next;
    logic [NW-1:0]           ilen_reg, ilen_next;
    logic [NW-1:0]           cur_reg, cur_next;
    logic [TW-1:0]           pos_reg, pos_next;
    logic [MAX_PATTERNS-1:0] found_reg, found_next;
    logic                    end_reg, end_next;
    logic [CHAR_W-1:0]       ch_reg, ch_next;
    status_t                 pend_reg, pend_next;
    logic [PIW-1:0]          k_reg, k_next;
    // build walker
    logic [NW-1:0]           t_reg, t_next;
    logic [NW-1:0]           f_reg, f_next;
    logic [CW-1:0]           c_reg, c_next;
    logic                    root_reg, root_next;
    logic [TRW-1:0]          rt_reg, rt_next;
    logic [MAX_PATTERNS-1:0] amf_reg, amf_next;
    logic [NCW-1:0]          head_reg, head_next;
    logic [NCW-1:0]          tail_reg, tail_next;
    // output register
    logic                    ov_reg, ov_next;
    status_t                 ost_reg, ost_next;
    logic [ID_W-1:0]         oid_reg, oid_next;
    logic                    ofd_reg, ofd_next;
    logic [POS_W-1:0]        opos_reg, opos_next;
    logic                    olast_reg, olast_next;
    // per pattern lanes
    logic [NW-1:0]           plen_reg [MAX_PATTERNS];
    logic [TW-1:0]           fs_reg   [MAX_PATTERNS];
    logic                    plen_we;
    logic [MAX_PATTERNS-1:0] hits;
    logic                    hits_we;

    // memory ports
    logic                    tr_we;
    logic [AW-1:0]           tr_waddr, tr_raddr;
    logic [TRW-1:0]          tr_wdata, tr_rdata;
    logic                    fl_we;
    logic [NW-1:0]           fl_waddr, fl_raddr, fl_wdata, fl_rdata;
    logic                    am_we;
    logic [NW-1:0]           am_waddr, am_raddr;
    logic [MAX_PATTERNS-1:0] am_wdata, am_rdata;
    logic                    q_we;
    logic [NW-1:0]           q_waddr, q_raddr, q_wdata, q_rdata;

    logic                    in_acc;
    logic                    in_valid_char;
    logic                    slot_free;
    logic [NW-1:0]           node_sel;
    logic [NW-1:0]           rf_node;
    logic [63:0]             fs_wide;

    mspm_ram #(.WIDTH(TRW), .DEPTH(DEPTH)) u_trans (
        .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
        .raddr(tr_raddr), .rdata(tr_rdata)
    );
    mspm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
        .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_rdata)
    );
    mspm_ram #(.WIDTH(MAX_PATTERNS), .DEPTH(MAX_NODES)) u_accept (
        .clk(clk), .we(am_we), .waddr(am_waddr), .wdata(am_wdata),
        .raddr(am_raddr), .rdata(am_rdata)
    );
    mspm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    assign req.ready     = (state_reg == S_IDLE);
    assign in_acc        = req.valid && req.ready;
    assign in_valid_char = (req.char_code != '0) && (32'(req.char_code) < ALPHABET);
    assign slot_free     = !ov_reg || rsp.ready;

    assign rsp.valid      = ov_reg;
    assign rsp.status     = ost_reg;
    assign rsp.pattern_id = oid_reg;
    assign rsp.found      = ofd_reg;
    assign rsp.start_pos  = opos_reg;
    assign rsp.last       = olast_reg;

    // root row has no failure row of its own: missing edges go to the root
    assign rf_node = root_reg ? '0 : tr_rdata[NW-1:0];
    assign fs_wide = 64'(fs_reg[k_reg]);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        nc_next     = nc_reg;
        pc_next     = pc_reg;
        built_next  = built_reg;
        skip_next   = skip_reg;
        cursor_next = cursor_reg;
        ilen_next   = ilen_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        end_next    = end_reg;
        ch_next     = ch_reg;
        pend_next   = pend_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        f_next      = f_reg;
        c_next      = c_reg;
        root_next   = root_reg;
        rt_next     = rt_reg;
        amf_next    = amf_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        ov_next     = ov_reg && !rsp.ready;
        ost_next    = ost_reg;
        oid_next    = oid_reg;
        ofd_next    = ofd_reg;
        opos_next   = opos_reg;
        olast_next  = olast_reg;
        plen_we     = 1'b0;
        hits        = '0;
        hits_we     = 1'b0;
        node_sel    = '0;
        tr_we       = 1'b0;
        tr_waddr    = '0;
        tr_wdata    = '0;
        tr_raddr    = '0;
        fl_we       = 1'b0;
        fl_waddr    = '0;
        fl_wdata    = '0;
        fl_raddr    = '0;
        am_we       = 1'b0;
        am_waddr    = '0;
        am_wdata    = '0;
        am_raddr    = '0;
        q_we        = 1'b0;
        q_waddr     = tail_reg[NW-1:0];
        q_wdata     = '0;
        q_raddr     = head_reg[NW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                tr_we    = 1'b1;
                tr_waddr = clr_reg;
                if (32'(clr_reg) < MAX_NODES)
                begin
                    fl_we    = 1'b1;
                    fl_waddr = clr_reg[NW-1:0];
                    am_we    = 1'b1;
                    am_waddr = clr_reg[NW-1:0];
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    end_next = req.pattern_end;
                    ch_next  = req.char_code;
                    case (req.req_type)
                        REQ_PATTERN:
                        begin
                            if (built_reg)
                            begin
                                pend_next  = ST_PHASE;
                                state_next = S_RESP;
                            end
                            else if (skip_reg)
                            begin
                                if (req.pattern_end)
                                begin
                                    cursor_next = '0;
                                    ilen_next   = '0;
                                    skip_next   = 1'b0;
                                end
                            end
                            else if (in_valid_char)
                            begin
                                if (pc_reg >= PCW'(MAX_PATTERNS))
                                begin
                                    cursor_next = '0;
                                    ilen_next   = '0;
                                    skip_next   = !req.pattern_end;
                                    pend_next   = ST_CAPACITY;
                                    state_next  = S_RESP;
                                end
                                else
                                begin
                                    tr_raddr   = AW'(cursor_reg) * AW'(ALPHABET)
                                                 + AW'(req.char_code);
                                    state_next = S_INS;
                                end
                            end
                            else if (req.pattern_end)
                            begin
                                if (ilen_reg == '0)
                                begin
                                    pend_next  = ST_CAPACITY;
                                    state_next = S_RESP;
                                end
                                else
                                begin
                                    am_raddr   = cursor_reg;
                                    state_next = S_ACC;
                                end
                            end
                        end
                        REQ_BUILD:
                        begin
                            if (built_reg)
                            begin
                                pend_next  = ST_PHASE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cursor_next = '0;
                                ilen_next   = '0;
                                skip_next   = 1'b0;
                                t_next      = '0;
                                f_next      = '0;
                                c_next      = CW'(1);
                                root_next   = 1'b1;
                                head_next   = '0;
                                tail_next   = '0;
                                state_next  = S_B_RT;
                            end
                        end
                        REQ_TEXT:
                        begin
                            if (!built_reg)
                            begin
                                pend_next  = ST_PHASE;
                                state_next = S_RESP;
                            end
                            else if (pos_reg >= TW'(MAX_TEXT))
                            begin
                                pend_next  = ST_CAPACITY;
                                state_next = S_RESP;
                            end
                            else if (in_valid_char)
                            begin
                                tr_raddr   = AW'(cur_reg) * AW'(ALPHABET)
                                             + AW'(req.char_code);
                                state_next = S_TXT_T;
                            end
                            else
                            begin
                                // invalid character: back to the root
                                cur_next   = '0;
                                am_raddr   = '0;
                                state_next = S_TXT_A;
                            end
                        end
                        default:
                        begin
                            if (!built_reg)
                            begin
                                pend_next  = ST_PHASE;
                                state_next = S_RESP;
                            end
                            else if (pc_reg == '0)
                            begin
                                cur_next   = '0;
                                pos_next   = '0;
                                found_next = '0;
                            end
                            else
                            begin
                                k_next     = '0;
                                state_next = S_REPORT;
                            end
                        end
                    endcase
                end
            end
            S_INS:
            begin
                if (!tr_rdata[NW] && nc_reg >= NCW'(MAX_NODES))
                begin
                    // trie full: drop the pattern
                    cursor_next = '0;
                    ilen_next   = '0;
                    skip_next   = !end_reg;
                    pend_next   = ST_CAPACITY;
                    state_next  = S_RESP;
                end
                else
                begin
                    if (tr_rdata[NW])
                    begin
                        node_sel = tr_rdata[NW-1:0];
                    end
                    else
                    begin
                        node_sel = nc_reg[NW-1:0];
                        tr_we    = 1'b1;
                        tr_waddr = AW'(cursor_reg) * AW'(ALPHABET) + AW'(ch_reg);
                        tr_wdata = {1'b1, node_sel};
                        nc_next  = nc_reg + 1'b1;
                    end
                    cursor_next = node_sel;
                    ilen_next   = ilen_reg + 1'b1;
                    if (end_reg)
                    begin
                        am_raddr   = node_sel;
                        state_next = S_ACC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ACC:
            begin
                am_we       = 1'b1;
                am_waddr    = cursor_reg;
                am_wdata    = am_rdata | (MAX_PATTERNS'(1) << pc_reg);
                plen_we     = 1'b1;
                pc_next     = pc_reg + 1'b1;
                cursor_next = '0;
                ilen_next   = '0;
                skip_next   = 1'b0;
                state_next  = S_IDLE;
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = pend_reg;
                    oid_next   = '0;
                    ofd_next   = 1'b0;
                    opos_next  = '0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TXT_T:
            begin
                cur_next   = tr_rdata[NW-1:0];
                am_raddr   = tr_rdata[NW-1:0];
                state_next = S_TXT_A;
            end
            S_TXT_A:
            begin
                hits       = am_rdata & ~found_reg;
                hits_we    = 1'b1;
                found_next = found_reg | hits;
                pos_next   = pos_reg + 1'b1;
                state_next = S_IDLE;
            end
            S_REPORT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = ST_REPORT;
                    oid_next   = ID_W'(k_reg);
                    ofd_next   = found_reg[k_reg];
                    if (!found_reg[k_reg])
                    begin
                        opos_next = '0;
                    end
                    else if (fs_wide > 64'(POS_SAT))
                    begin
                        opos_next = POS_SAT;
                    end
                    else
                    begin
                        opos_next = fs_wide[POS_W-1:0];
                    end
                    olast_next = (PCW'(k_reg) + 1'b1 == pc_reg);
                    k_next     = k_reg + 1'b1;
                    if (PCW'(k_reg) + 1'b1 == pc_reg)
                    begin
                        cur_next   = '0;
                        pos_next   = '0;
                        found_next = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            S_B_RT:
            begin
                tr_raddr   = AW'(t_reg) * AW'(ALPHABET) + AW'(c_reg);
                state_next = S_B_RF;
            end
            S_B_RF:
            begin
                rt_next    = tr_rdata;
                tr_raddr   = AW'(f_reg) * AW'(ALPHABET) + AW'(c_reg);
                state_next = S_B_C;
            end
            S_B_C:
            begin
                if (!rt_reg[NW])
                begin
                    // missing edge takes the failure node's edge
                    tr_we    = 1'b1;
                    tr_waddr = AW'(t_reg) * AW'(ALPHABET) + AW'(c_reg);
                    tr_wdata = {1'b0, rf_node};
                    c_next   = c_reg + 1'b1;
                    if (c_reg == CW'(ALPHABET - 1))
                    begin
                        state_next = S_B_DEQ;
                    end
                    else
                    begin
                        state_next = S_B_RT;
                    end
                end
                else
                begin
                    fl_we    = 1'b1;
                    fl_waddr = rt_reg[NW-1:0];
                    fl_wdata = rf_node;
                    if (32'(tail_reg) < MAX_NODES)
                    begin
                        q_we      = 1'b1;
                        q_wdata   = rt_reg[NW-1:0];
                        tail_next = tail_reg + 1'b1;
                    end
                    am_raddr   = rf_node;
                    state_next = S_B_A1;
                end
            end
            S_B_A1:
            begin
                amf_next   = am_rdata;
                am_raddr   = rt_reg[NW-1:0];
                state_next = S_B_A2;
            end
            S_B_A2:
            begin
                am_we    = 1'b1;
                am_waddr = rt_reg[NW-1:0];
                am_wdata = am_rdata | amf_reg;
                c_next   = c_reg + 1'b1;
                if (c_reg == CW'(ALPHABET - 1))
                begin
                    state_next = S_B_DEQ;
                end
                else
                begin
                    state_next = S_B_RT;
                end
            end
            S_B_DEQ:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_B_DQ2;
                end
                else
                begin
                    built_next = 1'b1;
                    cur_next   = '0;
                    pos_next   = '0;
                    found_next = '0;
                    pend_next  = ST_BUILT;
                    state_next = S_RESP;
                end
            end
            S_B_DQ2:
            begin
                t_next     = q_rdata;
                fl_raddr   = q_rdata;
                state_next = S_B_DQ3;
            end
            S_B_DQ3:
            begin
                f_next     = fl_rdata;
                root_next  = 1'b0;
                c_next     = CW'(1);
                state_next = S_B_RT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            nc_reg     <= NCW'(1);
            pc_reg     <= '0;
            built_reg  <= 1'b0;
            skip_reg   <= 1'b0;
            cursor_reg <= '0;
            ilen_reg   <= '0;
            cur_reg    <= '0;
            pos_reg    <= '0;
            found_reg  <= '0;
            k_reg      <= '0;
            root_reg   <= 1'b1;
            head_reg   <= '0;
            tail_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            nc_reg     <= nc_next;
            pc_reg     <= pc_next;
            built_reg  <= built_next;
            skip_reg   <= skip_next;
            cursor_reg <= cursor_next;
            ilen_reg   <= ilen_next;
            cur_reg    <= cur_next;
            pos_reg    <= pos_next;
            found_reg  <= found_next;
            k_reg      <= k_next;
            root_reg   <= root_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            ov_reg     <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        end_reg   <= end_next;
        ch_reg    <= ch_next;
        pend_reg  <= pend_next;
        t_reg     <= t_next;
        f_reg     <= f_next;
        c_reg     <= c_next;
        rt_reg    <= rt_next;
        amf_reg   <= amf_next;
        ost_reg   <= ost_next;
        oid_reg   <= oid_next;
        ofd_reg   <= ofd_next;
        opos_reg  <= opos_next;
        olast_reg <= olast_next;
    end

    // one lane per pattern: length and first start index
    for (genvar g = 0; g < MAX_PATTERNS; g++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (plen_we && pc_reg == PCW'(g))
            begin
                plen_reg[g] <= ilen_reg;
            end
            if (hits_we && hits[g])
            begin
                if (TW'(plen_reg[g]) <= pos_reg + 1'b1)
                begin
                    fs_reg[g] <= pos_reg + 1'b1 - TW'(plen_reg[g]);
                end
                else
                begin
                    fs_reg[g] <= '0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // no request is taken while the clearing pass runs
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !req.ready)
        else $error("request taken during clearing pass");

    // the trie never grows beyond its capacity
    a_node_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(nc_reg) <= MAX_NODES)
        else $error("node count beyond capacity");

    // the walk never dequeues past the tail
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("walk queue head passed tail");

    // a pending result never overwrites one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !rsp.ready) |=> (ov_reg && $stable(ost_reg) && $stable(oid_reg)))
        else $error("stalled result overwritten");
`endif

endmodule
